// ===== hw/rtl/ptts_pkg.sv =====
// Package for the preemptive tick scheduler.
// Holds the operation codes, sequencer states and task entry type; no dependencies.
package ptts_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  localparam int unsigned REM_W  = 8;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned PRI_W  = 8;
  localparam int unsigned TCNT_W = 4;
  localparam int unsigned SLOT_W = 3;

  localparam logic [TCNT_W-1:0] TASK_COUNT_RESET = TCNT_W'(1);

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [TIME_W-1:0] arr;
    logic [PRI_W-1:0]  pri;
  } task_entry_t;

endpackage

// ===== hw/rtl/ptts_if.sv =====
// Channel interfaces of the tick scheduler: task/tick input, result output, config write.
// Depends on ptts_pkg for field widths.
interface ptts_in_if;
  import ptts_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [SLOT_W-1:0] slot;
  logic [REM_W-1:0]  burst_time;
  logic [TIME_W-1:0] arrival_time;
  logic [PRI_W-1:0]  priority_level;

  modport source (output valid, operation, slot, burst_time, arrival_time, priority_level,
                  input ready);
  modport sink   (input valid, operation, slot, burst_time, arrival_time, priority_level,
                  output ready);
endinterface

interface ptts_out_if;
  import ptts_pkg::*;
  logic              valid;
  logic              ready;
  logic              idle;
  logic [SLOT_W-1:0] task_slot;
  logic              task_finished;
  logic [TIME_W-1:0] time_after_tick;
  logic              all_done;

  modport source (output valid, idle, task_slot, task_finished, time_after_tick, all_done,
                  input ready);
  modport sink   (input valid, idle, task_slot, task_finished, time_after_tick, all_done,
                  output ready);
endinterface

interface ptts_cfg_if;
  import ptts_pkg::*;
  logic              valid;
  logic              ready;
  logic [TCNT_W-1:0] task_count;

  modport source (output valid, task_count, input ready);
  modport sink   (input valid, task_count, output ready);
endinterface

// ===== hw/rtl/preemptive_task_tick_scheduler_top.sv =====
// Preemptive shortest-remaining-time-first tick scheduler, top level.
// Instantiates ptts_task_mem; uses ptts_pkg and the channels in ptts_if.
//
// A load item writes one slot of the task table; the block is ready again on the next cycle.
// A tick item walks the table one slot per cycle through a single compare unit fed by the
// table's registered read port: with n = min(task_count, MAX_TASKS) slots in use, a tick
// occupies the block from its transfer until ready returns, through an accept cycle in
// idle, the scan state, which reads the n slots, and an update cycle in finish. The result
// sits in an output register, so a new item may be taken while it waits; a following tick
// holds in its update cycle until that register is free. No result is produced for loads.
// task_count is written through the config channel, which is always ready; it resets to 1.
module preemptive_task_tick_scheduler_top #(
  parameter int unsigned MAX_TASKS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptts_in_if.sink    in_i,
  ptts_out_if.source out_o,
  ptts_cfg_if.sink   cfg_i
);
  import ptts_pkg::*;

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  state_e            state_q, state_d;
  logic [TCNT_W-1:0] task_count_q;
  logic [TIME_W-1:0] cur_time_q;
  logic [CNT_W-1:0]  n_use;

  logic [CNT_W-1:0]  issue_q;
  logic              rd_vld_q;
  logic              found_q;
  logic [IDX_W-1:0]  rd_idx_q, best_idx_q;
  logic [REM_W-1:0]  best_rem_q;
  logic [PRI_W-1:0]  best_pri_q;
  logic [CNT_W-1:0]  zero_cnt_q;

  logic              out_valid_q;
  logic              out_idle_q, out_fin_q, out_done_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [TIME_W-1:0] out_time_q;

  logic              in_xfer, out_free, scan_issue, slot_ok, better;
  logic              finished;
  logic [CNT_W-1:0]  done_now;

  logic              wr_en, wr_rem_only;
  logic [IDX_W-1:0]  wr_addr;
  task_entry_t       wr_data, rd_data;

  // Slots beyond the table size are not in use.
  always_comb begin
    if (32'(task_count_q) > MAX_TASKS) n_use = CNT_W'(MAX_TASKS);
    else                               n_use = CNT_W'(task_count_q);
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign slot_ok     = 32'(in_i.slot) < MAX_TASKS;
  assign scan_issue  = (state_q == ST_SCAN) && (issue_q < n_use);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= TASK_COUNT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      task_count_q <= cfg_i.task_count;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_i.operation == OP_TICK) state_d = ST_SCAN;
      end
      // last read is evaluated at the same edge that leaves scan
      ST_SCAN: begin
        if (issue_q == n_use) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Shared compare unit: one table entry per cycle.
  assign better = (rd_data.rem != '0) && (rd_data.arr <= cur_time_q) &&
                  (!found_q || (rd_data.rem < best_rem_q) ||
                   ((rd_data.rem == best_rem_q) && (rd_data.pri < best_pri_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (state_q == ST_IDLE) begin
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      rd_vld_q <= scan_issue;
      if (scan_issue) issue_q <= issue_q + CNT_W'(1);
      if (rd_vld_q && better) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      zero_cnt_q <= '0;
    end else if (state_q == ST_SCAN) begin
      rd_idx_q <= issue_q[IDX_W-1:0];
      if (rd_vld_q) begin
        if (rd_data.rem == '0) zero_cnt_q <= zero_cnt_q + CNT_W'(1);
        if (better) begin
          best_idx_q <= rd_idx_q;
          best_rem_q <= rd_data.rem;
          best_pri_q <= rd_data.pri;
        end
      end
    end
  end

  assign finished = found_q && (best_rem_q == REM_W'(1));
  assign done_now = zero_cnt_q + CNT_W'(finished);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_time_q <= '0;
    end else if (state_q == ST_FINISH && out_free) begin
      cur_time_q <= cur_time_q + TIME_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      out_idle_q <= !found_q;
      out_slot_q <= found_q ? SLOT_W'(best_idx_q) : '0;
      out_fin_q  <= finished;
      out_time_q <= cur_time_q + TIME_W'(1);
      out_done_q <= (done_now == n_use);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.idle            = out_idle_q;
  assign out_o.task_slot       = out_slot_q;
  assign out_o.task_finished   = out_fin_q;
  assign out_o.time_after_tick = out_time_q;
  assign out_o.all_done        = out_done_q;

  // Table write: loads from idle, remaining-time decrement from the update cycle.
  always_comb begin
    wr_en       = 1'b0;
    wr_rem_only = 1'b0;
    wr_addr     = IDX_W'(in_i.slot);
    wr_data.rem = in_i.burst_time;
    wr_data.arr = in_i.arrival_time;
    wr_data.pri = in_i.priority_level;
    if (state_q == ST_FINISH) begin
      wr_en       = out_free && found_q;
      wr_rem_only = 1'b1;
      wr_addr     = best_idx_q;
      wr_data.rem = best_rem_q - REM_W'(1);
    end else if (state_q == ST_IDLE) begin
      wr_en = in_xfer && (in_i.operation == OP_LOAD) && slot_ok;
    end
  end

  ptts_task_mem #(
    .MAX_TASKS (MAX_TASKS),
    .IDX_W     (IDX_W)
  ) u_task_mem (
    .clk_i         (clk_i),
    .wr_en_i       (wr_en),
    .wr_rem_only_i (wr_rem_only),
    .wr_addr_i     (wr_addr),
    .wr_data_i     (wr_data),
    .rd_en_i       (scan_issue),
    .rd_addr_i     (issue_q[IDX_W-1:0]),
    .rd_data_o     (rd_data)
  );

endmodule

// ===== hw/rtl/ptts_task_mem.sv =====
// Task table: remaining ticks, arrival time and priority per slot.
// One write port, one registered read port. Depends on ptts_pkg.
module ptts_task_mem #(
  parameter int unsigned MAX_TASKS = 8,
  parameter int unsigned IDX_W     = $clog2(MAX_TASKS)
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic                  wr_rem_only_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  ptts_pkg::task_entry_t wr_data_i,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  output ptts_pkg::task_entry_t rd_data_o
);
  import ptts_pkg::*;

  logic [REM_W-1:0]  rem_mem [MAX_TASKS];
  logic [TIME_W-1:0] arr_mem [MAX_TASKS];
  logic [PRI_W-1:0]  pri_mem [MAX_TASKS];
  task_entry_t       rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rem_mem[wr_addr_i] <= wr_data_i.rem;
      if (!wr_rem_only_i) begin
        arr_mem[wr_addr_i] <= wr_data_i.arr;
        pri_mem[wr_addr_i] <= wr_data_i.pri;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q.rem <= rem_mem[rd_addr_i];
      rd_data_q.arr <= arr_mem[rd_addr_i];
      rd_data_q.pri <= pri_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/ptts_checker.sv =====
// Port-level assertions for the tick scheduler, bound to the top level.
// Depends on ptts_pkg for the operation codes.
module ptts_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    in_operation_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic                    out_idle_i,
  input logic [ptts_pkg::SLOT_W-1:0] out_task_slot_i,
  input logic                    out_task_finished_i
);
  import ptts_pkg::*;

  // result stays offered until transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // a tick keeps the block busy for at least the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_operation_i == OP_TICK |=> !in_ready_i)
    else $error("ready after tick transfer");

  // a load completes in its transfer cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_operation_i == OP_LOAD |=> in_ready_i)
    else $error("not ready after load transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_idle_i |-> (out_task_slot_i == '0) && !out_task_finished_i)
    else $error("idle result carries a task");

endmodule

bind preemptive_task_tick_scheduler_top ptts_checker u_ptts_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .in_operation_i      (in_i.operation),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_idle_i          (out_o.idle),
  .out_task_slot_i     (out_o.task_slot),
  .out_task_finished_i (out_o.task_finished)
);
